// ===== hw/rtl/csvt_pkg.sv =====
package csvt_pkg;

  // Default for the largest number of columns in one row.
  localparam int MaxColumnsDef = 64;

  // Depths of the token queue and the result queue (powers of two).
  localparam int TokQueueDepth = 2;
  localparam int ResQueueDepth = 2;

  // Register reset value.
  localparam logic [9:0] MaxFieldCharsRst = 10'd1023;

  // Characters with a meaning of their own.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;

  // Input function codes.
  localparam logic FuncData = 1'b0;
  localparam logic FuncEor  = 1'b1;

  // Result kinds.
  localparam logic KindChar    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Row status codes.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnclosed = 2'd1;
  localparam logic [1:0] StTooMany = 2'd2;
  localparam logic [1:0] StTooLong = 2'd3;

  typedef enum logic [1:0] {
    TokData  = 2'd0,
    TokQuote = 2'd1,
    TokComma = 2'd2,
    TokEor   = 2'd3
  } tok_cls_e;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_char;
    logic [5:0] column_index;
    logic [1:0] row_status;
    logic [6:0] column_count;
  } out_t;

  typedef struct packed {
    tok_cls_e   cls;
    logic [7:0] data;
  } tok_t;

endpackage

// ===== hw/rtl/csvt_fifo.sv =====
module csvt_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/csvt_front.sv =====
module csvt_front (
  input  csvt_pkg::in_t  in_i,
  output csvt_pkg::tok_t tok_o
);

  // Sort each beat into end of row, quote, comma or plain data.
  always_comb begin
    tok_o.data = in_i.in_byte;
    priority if (in_i.func == csvt_pkg::FuncEor) begin
      tok_o.cls = csvt_pkg::TokEor;
    end else if (in_i.in_byte == csvt_pkg::ChQuote) begin
      tok_o.cls = csvt_pkg::TokQuote;
    end else if (in_i.in_byte == csvt_pkg::ChComma) begin
      tok_o.cls = csvt_pkg::TokComma;
    end else begin
      tok_o.cls = csvt_pkg::TokData;
    end
  end

endmodule

// ===== hw/rtl/csvt_back.sv =====
module csvt_back #(
  parameter int MaxColumns = csvt_pkg::MaxColumnsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [9:0]     max_field_chars_i,
  input  logic           tok_valid_i,
  input  csvt_pkg::tok_t tok_i,
  output logic           tok_take_o,
  input  logic           res_full_i,
  output logic           res_valid_o,
  output csvt_pkg::out_t res_o
);

  localparam int ColW = $clog2(MaxColumns);
  localparam logic [ColW-1:0] LastCol = ColW'(MaxColumns - 1);

  logic            quoted_q, quoted_d;
  logic            pend_q, pend_d;
  logic [ColW-1:0] col_q, col_d;
  logic [9:0]      flen_q, flen_d;
  logic [1:0]      err_q, err_d;
  logic            started_q, started_d;

  logic [8:0] col_ext;
  logic [8:0] col_cnt;

  assign tok_take_o = tok_valid_i && !res_full_i;
  assign col_ext    = 9'(col_q);
  assign col_cnt    = col_ext + 9'd1;

  always_comb begin
    logic       q_eff;
    logic       emit_req;
    logic [7:0] emit_ch;
    logic       q_end;
    logic [1:0] status;

    quoted_d    = quoted_q;
    pend_d      = pend_q;
    col_d       = col_q;
    flen_d      = flen_q;
    err_d       = err_q;
    started_d   = started_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    q_eff       = quoted_q;
    emit_req    = 1'b0;
    emit_ch     = tok_i.data;
    q_end       = quoted_q && !pend_q;
    status      = err_q;

    if (tok_take_o) begin
      if (tok_i.cls == csvt_pkg::TokEor) begin
        if (started_q) begin
          // A pending quote closes the field, so only a still open quote counts.
          if (err_q == csvt_pkg::StOk && q_end) begin
            status = csvt_pkg::StUnclosed;
          end
          res_valid_o        = 1'b1;
          res_o.kind         = csvt_pkg::KindSummary;
          res_o.row_status   = status;
          res_o.column_count = (status == csvt_pkg::StOk) ? col_cnt[6:0] : 7'd0;
        end
        quoted_d  = 1'b0;
        pend_d    = 1'b0;
        col_d     = '0;
        flen_d    = '0;
        err_d     = csvt_pkg::StOk;
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        if (err_q == csvt_pkg::StOk) begin
          if (pend_q && tok_i.cls == csvt_pkg::TokQuote) begin
            // Doubled quote inside quotes gives one literal quote.
            pend_d   = 1'b0;
            emit_req = 1'b1;
            emit_ch  = csvt_pkg::ChQuote;
          end else begin
            if (pend_q) begin
              pend_d   = 1'b0;
              q_eff    = 1'b0;
              quoted_d = 1'b0;
            end
            unique case (tok_i.cls)
              csvt_pkg::TokQuote: begin
                if (q_eff) begin
                  pend_d = 1'b1;
                end else begin
                  quoted_d = 1'b1;
                end
              end
              csvt_pkg::TokComma: begin
                if (q_eff) begin
                  emit_req = 1'b1;
                end else if (col_q == LastCol) begin
                  err_d = csvt_pkg::StTooMany;
                end else begin
                  col_d  = col_q + 1'b1;
                  flen_d = '0;
                end
              end
              default: begin
                emit_req = 1'b1;
              end
            endcase
          end
          if (emit_req) begin
            if (flen_q >= max_field_chars_i) begin
              err_d = csvt_pkg::StTooLong;
            end else begin
              flen_d             = flen_q + 1'b1;
              res_valid_o        = 1'b1;
              res_o.kind         = csvt_pkg::KindChar;
              res_o.out_char     = emit_ch;
              res_o.column_index = col_ext[5:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      pend_q    <= 1'b0;
      col_q     <= '0;
      flen_q    <= '0;
      err_q     <= csvt_pkg::StOk;
      started_q <= 1'b0;
    end else begin
      quoted_q  <= quoted_d;
      pend_q    <= pend_d;
      col_q     <= col_d;
      flen_q    <= flen_d;
      err_q     <= err_d;
      started_q <= started_d;
    end
  end

endmodule

// ===== hw/rtl/csv_row_tokenizer.sv =====
// Data flow: an accepted beat is written into the token queue, taken from it by the back end
// and, if it produces a result, written into the result queue, from which it can be popped.
// Throughput: one beat per cycle sustained in and out; the back end updates the row state
// for each token it takes, and each side stalls only when its own queue is full or empty.
// Reset: rst_ni is asynchronous and active low; it empties both queues, clears the row
// state and sets max_field_chars to 1023.
module csv_row_tokenizer #(
  parameter int MaxColumns = csvt_pkg::MaxColumnsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  csvt_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output csvt_pkg::out_t out_o,
  input  logic           cfg_we_i,
  input  logic [9:0]     cfg_wdata_i
);

  // Width of one token as it sits in the queue between front and back end.
  localparam int TokW = $bits(csvt_pkg::tok_t);
  localparam int ResW = $bits(csvt_pkg::out_t);

  logic [9:0] max_field_chars_q;

  csvt_pkg::tok_t front_tok;
  logic [TokW-1:0] tq_data;
  csvt_pkg::tok_t back_tok;
  logic tq_empty;
  logic tq_take;

  csvt_pkg::out_t back_res;
  logic back_res_valid;
  logic rq_full;
  logic [ResW-1:0] rq_data;

  // The one configuration register. The user must write it only while the block is idle,
  // which the block itself does not enforce, so that the back end may read it directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_field_chars_q <= csvt_pkg::MaxFieldCharsRst;
    end else if (cfg_we_i) begin
      max_field_chars_q <= cfg_wdata_i;
    end
  end

  // Front end: classifies each incoming beat as data, quote, comma or end of row.
  csvt_front u_front (
    .in_i  (in_i),
    .tok_o (front_tok)
  );

  // Token queue: decouples the classifier from the row-state machine. The push side
  // sees it as the block's own input queue, so full comes straight from it.
  csvt_fifo #(
    .Width (TokW),
    .Depth (csvt_pkg::TokQueueDepth)
  ) u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_tok),
    .full_o  (full),
    .pop_i   (tq_take),
    .data_o  (tq_data),
    .empty_o (tq_empty)
  );

  assign back_tok = csvt_pkg::tok_t'(tq_data);

  // Back end: quote handling, column counting, length checks and the row summary.
  // It takes a token only when the result queue has room, whether or not the token
  // will produce a result.
  csvt_back #(
    .MaxColumns (MaxColumns)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_field_chars_i (max_field_chars_q),
    .tok_valid_i       (!tq_empty),
    .tok_i             (back_tok),
    .tok_take_o        (tq_take),
    .res_full_i        (rq_full),
    .res_valid_o       (back_res_valid),
    .res_o             (back_res)
  );

  // Result queue: holds finished beats until the consumer pops them, so a stalled
  // consumer does not stop the back end straight away.
  csvt_fifo #(
    .Width (ResW),
    .Depth (csvt_pkg::ResQueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_res_valid),
    .data_i  (back_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_data),
    .empty_o (empty)
  );

  assign out_o = csvt_pkg::out_t'(rq_data);

  // The back end must never produce a result into a full result queue.
  a_no_res_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_res_valid |-> !rq_full)
    else $error("result produced while the result queue is full");

  // An accepted beat is in the token queue at the next edge.
  a_tok_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !tq_empty)
    else $error("accepted beat did not reach the token queue");

  // A summary with an error status reports no column count.
  a_err_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.kind == csvt_pkg::KindSummary && out_o.row_status != csvt_pkg::StOk)
    |-> (out_o.column_count == 7'd0))
    else $error("error summary carries a column count");

  // A character beat never carries summary fields.
  a_char_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.kind == csvt_pkg::KindChar)
    |-> (out_o.row_status == csvt_pkg::StOk && out_o.column_count == 7'd0))
    else $error("character beat carries summary fields");

endmodule

// ===== dv/csv_row_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module csv_row_tokenizer_tb;

  // A beat passes through the token queue and then the result queue. Its two small queues can hold a few more
  // beats that produce nothing, so the settle time after the last result is generous.
  localparam int SettleCycles  = 8;
  // The receiver holds off this long once, so that both internal queues fill and the
  // input side has to stall.
  localparam int LongHold      = 300;
  // No beat may be accepted on either side for this many cycles before the run is
  // declared hung. It is several times the long hold plus the longest random stall.
  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 6;
  localparam int PhaseBeats    = 160;

  // Scoreboard: keeps its own copy of the row state and the field limit, works out
  // what each accepted input beat should produce, and checks the result beats in order.
  class csv_row_sb;
    logic [9:0]     field_limit;
    bit             in_quotes;
    bit             quote_held;
    bit             row_open;
    int unsigned    col;
    int unsigned    field_len;
    logic [1:0]     row_err;
    csvt_pkg::out_t expected_tokens[$];
    int unsigned    n_fail;

    function new();
      field_limit = csvt_pkg::MaxFieldCharsRst;
      n_fail      = 0;
      clear_row();
    endfunction

    function void clear_row();
      in_quotes  = 1'b0;
      quote_held = 1'b0;
      row_open   = 1'b0;
      col        = 0;
      field_len  = 0;
      row_err    = csvt_pkg::StOk;
    endfunction

    function void set_limit(logic [9:0] v);
      field_limit = v;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    // Appends one character to the current field, or latches the over-length error.
    function void append_char(logic [7:0] ch);
      csvt_pkg::out_t tok;
      if (field_len >= field_limit) begin
        row_err = csvt_pkg::StTooLong;
        return;
      end
      field_len++;
      tok              = '0;
      tok.kind         = csvt_pkg::KindChar;
      tok.out_char     = ch;
      tok.column_index = 6'(col);
      expected_tokens.push_back(tok);
    endfunction

    // Row tokeniser proper: one input beat in, zero or one expected result out.
    function void note_input(csvt_pkg::in_t beat);
      csvt_pkg::out_t tok;
      logic [1:0]     status;
      if (beat.func == csvt_pkg::FuncEor) begin
        if (row_open) begin
          // A quote still held at the end of the row simply closes the quoted field.
          if (quote_held) in_quotes = 1'b0;
          status           = (row_err == csvt_pkg::StOk && in_quotes) ?
                             csvt_pkg::StUnclosed : row_err;
          tok              = '0;
          tok.kind         = csvt_pkg::KindSummary;
          tok.row_status   = status;
          tok.column_count = (status == csvt_pkg::StOk) ? 7'(col + 1) : 7'd0;
          expected_tokens.push_back(tok);
        end
        clear_row();
        return;
      end
      row_open = 1'b1;
      if (row_err != csvt_pkg::StOk) return;
      if (quote_held) begin
        quote_held = 1'b0;
        if (beat.in_byte == csvt_pkg::ChQuote) begin
          append_char(csvt_pkg::ChQuote);
          return;
        end
        in_quotes = 1'b0;
      end
      if (beat.in_byte == csvt_pkg::ChQuote) begin
        if (in_quotes) quote_held = 1'b1;
        else in_quotes = 1'b1;
      end else if (beat.in_byte == csvt_pkg::ChComma && !in_quotes) begin
        if (col + 1 >= csvt_pkg::MaxColumnsDef) begin
          row_err = csvt_pkg::StTooMany;
        end else begin
          col++;
          field_len = 0;
        end
      end else begin
        append_char(beat.in_byte);
      end
    endfunction

    function void flag(string what, csvt_pkg::out_t want, csvt_pkg::out_t got);
      n_fail++;
      if (n_fail <= 10) begin
        $display("%0t: %s: expected kind %0d char %02h col %0d status %0d count %0d",
                 $time, what, want.kind, want.out_char, want.column_index,
                 want.row_status, want.column_count);
        $display("%0t: %s: actual   kind %0d char %02h col %0d status %0d count %0d",
                 $time, what, got.kind, got.out_char, got.column_index,
                 got.row_status, got.column_count);
      end
    endfunction

    function void check_result(csvt_pkg::out_t got);
      csvt_pkg::out_t want;
      if (expected_tokens.size() == 0) begin
        flag("result beat with nothing expected", '0, got);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.out_char !== want.out_char ||
          got.column_index !== want.column_index || got.row_status !== want.row_status ||
          got.column_count !== want.column_count)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           push;
  logic           full;
  csvt_pkg::in_t  in_i;
  logic           empty;
  logic           pop;
  csvt_pkg::out_t out_o;
  logic           cfg_we_i;
  logic [9:0]     cfg_wdata_i;

  csv_row_sb      sb;
  csvt_pkg::in_t  row_beats[$];
  logic [9:0]     cur_limit;
  int             n_sent;
  bit             idling_on;
  bit             row_gaps;
  bit             hold_req;

  always #5 clk_i = ~clk_i;

  csv_row_tokenizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Offers one beat and returns at the edge where it is taken. Push is left high so
  // that back-to-back beats keep it high; it is only lowered for a gap or a drain.
  task automatic send_beat(csvt_pkg::in_t beat);
    if (row_gaps && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= beat;
    do @(posedge clk_i); while (full);
    sb.note_input(beat);
    n_sent++;
  endtask

  function automatic void add_byte(logic [7:0] b);
    row_beats.push_back('{func: csvt_pkg::FuncData, in_byte: b});
  endfunction

  // The byte that ends the row is random as well; the block must ignore it.
  function automatic void add_eor();
    row_beats.push_back('{func: csvt_pkg::FuncEor, in_byte: 8'($urandom)});
  endfunction

  task automatic send_row();
    row_gaps = idling_on && ($urandom_range(0, 3) != 0);
    while (row_beats.size() != 0) send_beat(row_beats.pop_front());
  endtask

  // Stops offering and waits until every expected result has been taken, then lets
  // the block settle so that any beats which produce nothing have left it as well.
  task automatic wait_for_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_field_limit(logic [9:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(v);
    cur_limit = v;
  endtask

  // Plain field bytes: anything except a quote or a comma.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == csvt_pkg::ChQuote || b == csvt_pkg::ChComma);
    return b;
  endfunction

  // Mostly short fields; with a small limit, lengths cluster round the limit so
  // that both just-fitting and just-too-long fields turn up often.
  function automatic int pick_len();
    if (cur_limit <= 10'd12 && $urandom_range(0, 2) == 0)
      return $urandom_range(0, int'(cur_limit) + 1);
    return $urandom_range(0, 5);
  endfunction

  // A well-formed row with random content. Now and then it is very wide, around the
  // column limit, with near-empty fields to keep it cheap.
  task automatic send_formed_row();
    int         n_cols;
    int         len;
    bit         quoted;
    logic [7:0] b;
    n_cols = ($urandom_range(0, 19) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 5);
    for (int c = 0; c < n_cols; c++) begin
      if (c > 0) add_byte(csvt_pkg::ChComma);
      len    = (n_cols > 8) ? $urandom_range(0, 1) : pick_len();
      quoted = ($urandom_range(0, 2) == 0);
      if (quoted) add_byte(csvt_pkg::ChQuote);
      for (int i = 0; i < len; i++) begin
        if (quoted) begin
          // Inside quotes a comma is literal and a quote must be doubled.
          b = ($urandom_range(0, 5) == 0) ? csvt_pkg::ChComma : 8'($urandom);
          add_byte(b);
          if (b == csvt_pkg::ChQuote) add_byte(csvt_pkg::ChQuote);
        end else begin
          add_byte(plain_byte());
        end
      end
      if (quoted) add_byte(csvt_pkg::ChQuote);
    end
    add_eor();
    send_row();
  endtask

  // Noise: short rows heavy in quotes and commas, including empty rows, unclosed
  // quotes and characters straight after a closing quote.
  task automatic send_noise_row();
    int n;
    int pick;
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 5);
      if (pick < 2) add_byte(csvt_pkg::ChQuote);
      else if (pick == 2) add_byte(csvt_pkg::ChComma);
      else add_byte(8'($urandom));
    end
    add_eor();
    send_row();
  endtask

  // Receiver: takes results, stalling in random bursts, and once holds off for a
  // long stretch on request from the stimulus.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) sb.check_result(out_o);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if neither side has accepted a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("csv_row_tokenizer_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [9:0] phase_limit [NumPhases];
    int         start;
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    n_sent      = 0;
    idling_on   = 1'b1;
    row_gaps    = 1'b0;
    hold_req    = 1'b0;
    cur_limit   = csvt_pkg::MaxFieldCharsRst;
    sb          = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with a small field limit so that over-long fields are cheap.
    set_field_limit(10'd3);
    // An end of row on its own gives nothing.
    add_eor();
    // Zero and all-ones bytes, then a quoted field with a doubled quote whose closing
    // quote is still held when the row ends.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(csvt_pkg::ChComma);
    add_byte(csvt_pkg::ChQuote);
    add_byte(8'h61);
    add_byte(csvt_pkg::ChQuote);
    add_byte(csvt_pkg::ChQuote);
    add_byte(8'h62);
    add_byte(csvt_pkg::ChQuote);
    add_eor();
    // A quote left open, with a comma inside it that stays a character.
    add_byte(csvt_pkg::ChQuote);
    add_byte(csvt_pkg::ChComma);
    add_byte(8'h78);
    add_eor();
    // A field that grows too long; the quote after it is ignored, and the latched
    // error wins over the quote it would otherwise leave open.
    add_byte(8'h61);
    add_byte(8'h62);
    add_byte(8'h63);
    add_byte(8'h64);
    add_byte(csvt_pkg::ChQuote);
    add_eor();
    // A closing quote followed straight away by a comma.
    add_byte(csvt_pkg::ChQuote);
    add_byte(8'h71);
    add_byte(csvt_pkg::ChQuote);
    add_byte(csvt_pkg::ChComma);
    add_eor();
    send_row();

    // Random part: one setting of the field limit per phase, the extremes first.
    phase_limit[0] = 10'd0;
    phase_limit[1] = 10'd1;
    phase_limit[2] = 10'd1023;
    phase_limit[3] = 10'($urandom_range(2, 12));
    phase_limit[4] = 10'($urandom_range(13, 1022));
    phase_limit[5] = 10'($urandom_range(1, 6));
    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      set_field_limit(phase_limit[p]);
      // The closing phase runs flat out on both sides.
      idling_on = (p != NumPhases - 1);
      // Long receiver hold-off while the sender keeps offering beats.
      if (p == 1) hold_req = 1'b1;
      if (p == 2) begin
        // One field of the largest legal length plus one character, in a single row.
        for (int i = 0; i < 1024; i++) add_byte(plain_byte());
        add_eor();
        send_row();
      end
      start = n_sent;
      while (n_sent - start < PhaseBeats) begin
        if ($urandom_range(0, 4) == 0) send_noise_row();
        else send_formed_row();
      end
    end

    wait_for_results();
    sb.n_fail += sb.pending();
    if (sb.n_fail == 0) $display("csv_row_tokenizer_tb passed");
    else $display("csv_row_tokenizer_tb failed");
    $finish;
  end

endmodule
